// File: design/hcr_pkg.sv
// Shared types, constants and helper functions of the Harris corner response block.
// No dependencies; every module of the block imports this package.
package hcr_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DIM_MIN       = 5;
	localparam int DIM_MAX       = 2048;
	localparam int CNT_W         = 12;   // row/column counters and dimensions
	localparam int POS_W         = 11;   // result row/column
	localparam int RESP_W        = 20;
	localparam int CFG_DATA_W    = 17;
	localparam int CFG_IDX_W     = 3;
	localparam int CENTER_W      = 17;
	localparam int SIDE_W        = 16;
	localparam int GRAD_W        = 12;   // signed gradient, |g| <= 1020
	localparam int SQ_W          = 21;   // gx*gx, gy*gy
	localparam int XY_W          = 22;   // gx*gy, signed
	localparam int WPROD_W       = 33;   // product of two Q0.16 weights
	localparam int TAP_W         = 56;   // weight product times gradient product
	localparam int ACC_W         = 58;
	localparam int B_W           = 25;   // blurred value, signed
	localparam int M_W           = 2 * B_W;
	localparam int DET_W         = M_W + 1;
	localparam int TR_W          = B_W + 1;
	localparam int DIV_D_W       = TR_W - 1 + RESP_W;
	localparam logic [RESP_W-1:0] RESP_MAX = '1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_CENTER = 3'd2,
		CFG_SIDE   = 3'd3,
		CFG_ENABLE = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] gray_sample;
		logic       is_padding;
	} in_item_t;

	typedef struct packed {
		logic [RESP_W-1:0] response;
		logic [POS_W-1:0]  out_row;
		logic [POS_W-1:0]  out_col;
		logic              is_last;
	} out_item_t;

	// classified item from the front part
	typedef struct packed {
		logic       is_pixel;
		logic [7:0] sample;
	} front_item_t;

	// configuration seen by the back part
	typedef struct packed {
		logic [CNT_W-1:0]    width;
		logic [CNT_W-1:0]    height;
		logic [CENTER_W-1:0] center_w;
		logic [SIDE_W-1:0]   side_w;
		logic                blur_en;
		logic                restart;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GWR, ST_GRD, ST_GACC, ST_PROD, ST_CNT, ST_READY,
		ST_BRD, ST_BM0, ST_BM1, ST_BM2, ST_BM3, ST_RND,
		ST_DRD, ST_DLD, ST_DET, ST_DET2, ST_CHK, ST_DWAIT, ST_OUT
	} core_state_t;

	// reflect-101 border index
	function automatic logic [CNT_W-1:0] reflect101(input logic signed [CNT_W:0] k,
			input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		if (k < 0)
			r = CNT_W'(1);
		else if (k >= $signed({1'b0, n}))
			r = n - CNT_W'(2);
		else
			r = k[CNT_W-1:0];
		return r;
	endfunction

	// increment modulo three
	function automatic logic [1:0] mod3_inc(input logic [1:0] m);
		return (m == 2'd2) ? 2'd0 : m + 2'd1;
	endfunction

endpackage

// File: design/hcr_front.sv
// Front part: two-entry input queue that takes items and classifies pixel vs padding.
// Depends on hcr_pkg.
module hcr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hcr_pkg::in_item_t    item,
	output logic                 full,
	output logic                 valid,
	output hcr_pkg::front_item_t front_item,
	input  logic                 take
);
	import hcr_pkg::*;

	front_item_t entry_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;

	assign full       = (count_q == 2'd2);
	assign valid      = (count_q != 2'd0);
	assign front_item = entry_q[rd_ptr_q];
	assign do_push    = push && !full;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q].is_pixel <= !item.is_padding;
			entry_q[wr_ptr_q].sample   <= item.gray_sample;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (take && valid)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, take && valid};
		end
	end

endmodule

// File: design/hcr_res_fifo.sv
// Two-entry result queue between the back part and the result ports.
// Depends on hcr_pkg.
module hcr_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  hcr_pkg::out_item_t wr_data,
	output logic               space,
	output logic               empty,
	output hcr_pkg::out_item_t result,
	input  logic               pop
);
	import hcr_pkg::*;

	out_item_t  entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign space  = (count_q != 2'd2);
	assign empty  = (count_q == 2'd0);
	assign result = entry_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, wr} - {1'b0, do_pop};
		end
	end

endmodule

// File: design/hcr_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2^20.
// Depends on hcr_pkg.
module hcr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hcr_pkg::DIV_D_W-1:0] dividend,
	input  logic [hcr_pkg::TR_W-2:0]    divisor,
	output logic                        done,
	output logic [hcr_pkg::RESP_W-1:0]  quotient
);
	import hcr_pkg::*;

	localparam int STEP_W = $clog2(RESP_W + 1);

	logic [DIV_D_W-1:0] rem_q, den_q;
	logic [RESP_W-1:0]  quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               ge;

	assign ge       = (rem_q >= den_q);
	assign quotient = quo_q;
	assign done     = busy_q && (step_q == STEP_W'(0));

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= {divisor, {(RESP_W-1){1'b0}}, 1'b0} >> 1;
			quo_q <= '0;
		end else if (busy_q && step_q != STEP_W'(0)) begin
			if (ge)
				rem_q <= rem_q - den_q;
			quo_q <= {quo_q[RESP_W-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(RESP_W);
		end else if (busy_q) begin
			if (step_q == STEP_W'(0))
				busy_q <= 1'b0;
			else
				step_q <= step_q - STEP_W'(1);
		end
	end

endmodule

// File: design/hcr_core.sv
// Back part: line stores, gradient and product forming, blur, det/trace and result release.
// Depends on hcr_pkg and hcr_div.
module hcr_core #(
	parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hcr_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	input  hcr_pkg::front_item_t in_item,
	output logic                 in_take,
	input  logic                 res_space,
	output logic                 res_wr,
	output hcr_pkg::out_item_t   res_data
);
	import hcr_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int AW    = CW + 2;
	localparam int DEPTH = 4 << CW;

	// line stores
	logic [7:0]         gray_mem [DEPTH];
	logic [SQ_W-1:0]    xx_mem   [DEPTH];
	logic [SQ_W-1:0]    yy_mem   [DEPTH];
	logic signed [XY_W-1:0] xy_mem [DEPTH];

	core_state_t state_q, state_d;

	logic [CNT_W-1:0] ir_q, ic_q;
	logic [1:0]       irm3_q;
	logic             frame_rcv_q;
	logic [POS_W-1:0] or_q, oc_q;
	logic [7:0]       sample_q;
	logic [1:0]       ta_q, tb_q;
	logic signed [GRAD_W-1:0] gx_q, gy_q;
	logic [WPROD_W-1:0]       w_q;
	logic signed [TAP_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]  acc_xx_q, acc_yy_q, acc_xy_q;
	logic signed [B_W-1:0]    bxx_q, byy_q, bxy_q;
	logic signed [M_W-1:0]    m1_q, m2_q;
	logic signed [TR_W-1:0]   tr_q;
	logic signed [DET_W-1:0]  det_q;
	logic [RESP_W-1:0]        resp_q;

	logic [7:0]             g_rd_q;
	logic [SQ_W-1:0]        xx_rd_q, yy_rd_q;
	logic signed [XY_W-1:0] xy_rd_q;

	logic g_we, g_re, p_we, p_re, div_start;
	logic [AW-1:0] g_waddr, g_raddr, p_waddr, p_raddr;
	logic div_done;
	logic [RESP_W-1:0] div_quo;

	logic [CNT_W-1:0] gw, gh, need_r, need_c, or_x, oc_x;
	logic [CNT_W-1:0] g_col, refl_r, refl_c;
	logic [1:0]       g_row;
	logic             ready, last_tap, last_pos;
	logic [CENTER_W-1:0] wa, wb;
	logic signed [ACC_W-1:0] half;

	// frame geometry
	assign gw     = cfg.width - CNT_W'(2);
	assign gh     = cfg.height - CNT_W'(2);
	assign or_x   = CNT_W'(or_q);
	assign oc_x   = CNT_W'(oc_q);
	assign need_r = (or_x + CNT_W'(2) <= gh) ? or_x + CNT_W'(3) : or_x + CNT_W'(2);
	assign need_c = (oc_x + CNT_W'(2) <= gw) ? oc_x + CNT_W'(3) : oc_x + CNT_W'(2);
	assign ready  = frame_rcv_q || (ir_q > need_r) || (ir_q == need_r && ic_q > need_c);
	assign last_pos = (or_x == gh - CNT_W'(1)) && (oc_x == gw - CNT_W'(1));
	assign last_tap = (ta_q == 2'd2) && (tb_q == 2'd2);

	// gray window addressing: rows oldest to newest
	always_comb begin
		unique case (ta_q)
			2'd0:    g_row = mod3_inc(irm3_q);
			2'd1:    g_row = mod3_inc(mod3_inc(irm3_q));
			default: g_row = irm3_q;
		endcase
	end
	assign g_col   = ic_q - CNT_W'(2) + CNT_W'(tb_q);
	assign g_waddr = {irm3_q, CW'(ic_q)};
	assign g_raddr = {g_row, CW'(g_col)};
	assign p_waddr = {ir_q[1:0] - 2'd2, CW'(ic_q - CNT_W'(2))};

	// blur tap addressing with mirrored borders
	assign refl_r = reflect101($signed({2'b00, or_q}) + $signed({11'b0, ta_q}) - 13'sd1, gh);
	assign refl_c = reflect101($signed({2'b00, oc_q}) + $signed({11'b0, tb_q}) - 13'sd1, gw);
	assign p_raddr = (state_q == ST_BRD) ? {refl_r[1:0], CW'(refl_c)}
	                                     : {or_q[1:0], CW'(oc_q)};
	assign wa   = (ta_q == 2'd1) ? cfg.center_w : CENTER_W'(cfg.side_w);
	assign wb   = (tb_q == 2'd1) ? cfg.center_w : CENTER_W'(cfg.side_w);
	assign half = ACC_W'(64'sd2147483648);

	// memories
	always_ff @(posedge clk) begin
		if (g_we)
			gray_mem[g_waddr] <= sample_q;
		if (g_re)
			g_rd_q <= gray_mem[g_raddr];
		if (p_we) begin
			xx_mem[p_waddr] <= SQ_W'(gx_q * gx_q);
			yy_mem[p_waddr] <= SQ_W'(gy_q * gy_q);
			xy_mem[p_waddr] <= XY_W'(gx_q * gy_q);
		end
		if (p_re) begin
			xx_rd_q <= xx_mem[p_raddr];
			yy_rd_q <= yy_mem[p_raddr];
			xy_rd_q <= xy_mem[p_raddr];
		end
	end

	hcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_D_W'(det_q)),
		.divisor  (tr_q[TR_W-2:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		in_take   = 1'b0;
		g_we      = 1'b0;
		g_re      = 1'b0;
		p_we      = 1'b0;
		p_re      = 1'b0;
		div_start = 1'b0;
		res_wr    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && res_space) begin
					in_take = 1'b1;
					state_d = in_item.is_pixel ? ST_GWR : ST_READY;
				end
			end
			ST_GWR: begin
				g_we    = 1'b1;
				state_d = (ir_q >= CNT_W'(2) && ic_q >= CNT_W'(2)) ? ST_GRD : ST_CNT;
			end
			ST_GRD: begin
				g_re    = 1'b1;
				state_d = ST_GACC;
			end
			ST_GACC: state_d = last_tap ? ST_PROD : ST_GRD;
			ST_PROD: begin
				p_we    = 1'b1;
				state_d = ST_CNT;
			end
			ST_CNT:  state_d = ST_READY;
			ST_READY: begin
				if (!ready)
					state_d = ST_IDLE;
				else
					state_d = cfg.blur_en ? ST_BRD : ST_DRD;
			end
			ST_BRD: begin
				p_re    = 1'b1;
				state_d = ST_BM0;
			end
			ST_BM0:  state_d = ST_BM1;
			ST_BM1:  state_d = ST_BM2;
			ST_BM2:  state_d = ST_BM3;
			ST_BM3:  state_d = last_tap ? ST_RND : ST_BRD;
			ST_RND:  state_d = ST_DET;
			ST_DRD: begin
				p_re    = 1'b1;
				state_d = ST_DLD;
			end
			ST_DLD:  state_d = ST_DET;
			ST_DET:  state_d = ST_DET2;
			ST_DET2: state_d = ST_CHK;
			ST_CHK: begin
				if (tr_q <= 0 || det_q <= 0 ||
						det_q >= $signed(DET_W'({tr_q, {RESP_W{1'b0}}})))
					state_d = ST_OUT;
				else begin
					div_start = 1'b1;
					state_d   = ST_DWAIT;
				end
			end
			ST_DWAIT: if (div_done) state_d = ST_OUT;
			ST_OUT: begin
				res_wr  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result transaction
	assign res_data.response = resp_q;
	assign res_data.out_row  = or_q;
	assign res_data.out_col  = oc_q;
	assign res_data.is_last  = last_pos;

	// datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sample_q <= in_item.sample;
				ta_q     <= 2'd0;
				tb_q     <= 2'd0;
				gx_q     <= '0;
				gy_q     <= '0;
			end
			ST_GACC: begin
				// gx: bottom row minus top row; gy: left column minus right column
				if (ta_q == 2'd0)
					gx_q <= gx_q - GRAD_W'({g_rd_q, 1'b0} >> (tb_q != 2'd1));
				else if (ta_q == 2'd2)
					gx_q <= gx_q + GRAD_W'({g_rd_q, 1'b0} >> (tb_q != 2'd1));
				if (tb_q == 2'd0)
					gy_q <= gy_q + GRAD_W'({g_rd_q, 1'b0} >> (ta_q != 2'd1));
				else if (tb_q == 2'd2)
					gy_q <= gy_q - GRAD_W'({g_rd_q, 1'b0} >> (ta_q != 2'd1));
				tb_q <= (tb_q == 2'd2) ? 2'd0 : tb_q + 2'd1;
				if (tb_q == 2'd2)
					ta_q <= ta_q + 2'd1;
			end
			ST_READY: begin
				ta_q     <= 2'd0;
				tb_q     <= 2'd0;
				acc_xx_q <= '0;
				acc_yy_q <= '0;
				acc_xy_q <= '0;
			end
			ST_BRD: w_q <= WPROD_W'(wa * wb);
			ST_BM0: prod_q <= TAP_W'($signed({1'b0, w_q}) * $signed({1'b0, xx_rd_q}));
			ST_BM1: begin
				acc_xx_q <= acc_xx_q + ACC_W'(prod_q);
				prod_q   <= TAP_W'($signed({1'b0, w_q}) * $signed({1'b0, yy_rd_q}));
			end
			ST_BM2: begin
				acc_yy_q <= acc_yy_q + ACC_W'(prod_q);
				prod_q   <= TAP_W'($signed({1'b0, w_q}) * xy_rd_q);
			end
			ST_BM3: begin
				acc_xy_q <= acc_xy_q + ACC_W'(prod_q);
				tb_q <= (tb_q == 2'd2) ? 2'd0 : tb_q + 2'd1;
				if (tb_q == 2'd2)
					ta_q <= ta_q + 2'd1;
			end
			ST_RND: begin
				// round half up out of Q.32
				bxx_q <= B_W'((acc_xx_q + half) >>> 32);
				byy_q <= B_W'((acc_yy_q + half) >>> 32);
				bxy_q <= B_W'((acc_xy_q + half) >>> 32);
			end
			ST_DLD: begin
				bxx_q <= B_W'({1'b0, xx_rd_q});
				byy_q <= B_W'({1'b0, yy_rd_q});
				bxy_q <= B_W'(xy_rd_q);
			end
			ST_DET: begin
				m1_q <= bxx_q * byy_q;
				m2_q <= bxy_q * bxy_q;
				tr_q <= TR_W'(bxx_q) + TR_W'(byy_q);
			end
			ST_DET2: det_q <= DET_W'(m1_q) - DET_W'(m2_q);
			ST_CHK: begin
				if (tr_q <= 0 || det_q <= 0)
					resp_q <= '0;
				else
					resp_q <= RESP_MAX;
			end
			ST_DWAIT: if (div_done) resp_q <= div_quo;
			default: ;
		endcase
	end

	// frame counters and output position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_q        <= '0;
			ic_q        <= '0;
			irm3_q      <= 2'd0;
			frame_rcv_q <= 1'b0;
			or_q        <= '0;
			oc_q        <= '0;
		end else if (cfg.restart) begin
			ir_q        <= '0;
			ic_q        <= '0;
			irm3_q      <= 2'd0;
			frame_rcv_q <= 1'b0;
			or_q        <= '0;
			oc_q        <= '0;
		end else if (state_q == ST_CNT) begin
			if (ic_q + CNT_W'(1) == cfg.width) begin
				ic_q <= '0;
				if (ir_q + CNT_W'(1) == cfg.height) begin
					ir_q        <= '0;
					irm3_q      <= 2'd0;
					frame_rcv_q <= 1'b1;
					if (frame_rcv_q) begin
						or_q <= '0;
						oc_q <= '0;
					end
				end else begin
					ir_q   <= ir_q + CNT_W'(1);
					irm3_q <= mod3_inc(irm3_q);
				end
			end else
				ic_q <= ic_q + CNT_W'(1);
		end else if (state_q == ST_OUT) begin
			if (last_pos) begin
				or_q        <= '0;
				oc_q        <= '0;
				frame_rcv_q <= 1'b0;
			end else if (oc_x == gw - CNT_W'(1)) begin
				oc_q <= '0;
				or_q <= or_q + POS_W'(1);
			end else
				oc_q <= oc_q + POS_W'(1);
		end
	end

endmodule

// File: design/harris_corner_response.sv
// Harris corner response block: gray samples go in through a queue-style port, one
// corner response (floor of det over trace of the blurred gradient products) comes out
// per gradient pixel, in raster order, with its position. Items are handled one at a
// time by a sequencer: an interior pixel is worked through the line stores (nine reads
// of the gray store for the Sobel window), a border pixel is stored and counted with no
// gradient work, and a padding item goes straight to the result check. A released result
// runs through the blur (nine taps, three multiply-accumulates each) when blur is on,
// then det and trace, and the bit-serial divider when the quotient is neither zero nor
// saturated. A two-entry input queue and a two-entry result queue decouple the ports.
// Line stores are not cleared after reset; no clearing pass is run.
module harris_corner_response #(
	parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  hcr_pkg::in_item_t                item,
	output logic                             full,
	output logic                             empty,
	output hcr_pkg::out_item_t               result,
	input  logic                             pop,
	input  logic                             write_enable,
	input  logic [hcr_pkg::CFG_IDX_W-1:0]    reg_index,
	input  logic [hcr_pkg::CFG_DATA_W-1:0]   write_data
);
	import hcr_pkg::*;

	localparam int W_CAP = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;

	logic [CNT_W-1:0]    width_q, height_q;
	logic [CENTER_W-1:0] center_q;
	logic [SIDE_W-1:0]   side_q;
	logic                blur_en_q, restart_q;
	cfg_t                cfg;

	logic        f_valid, f_take, res_space, res_wr;
	front_item_t f_item;
	out_item_t   res_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= CNT_W'(640);
			height_q  <= CNT_W'(480);
			center_q  <= CENTER_W'(24939);
			side_q    <= SIDE_W'(20298);
			blur_en_q <= 1'b1;
			restart_q <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (write_enable) begin
				unique case (reg_index)
					CFG_WIDTH: begin
						width_q   <= write_data[CNT_W-1:0];
						restart_q <= 1'b1;
					end
					CFG_HEIGHT: begin
						height_q  <= write_data[CNT_W-1:0];
						restart_q <= 1'b1;
					end
					CFG_CENTER: center_q  <= write_data;
					CFG_SIDE:   side_q    <= write_data[SIDE_W-1:0];
					CFG_ENABLE: blur_en_q <= write_data[0];
					default: ;
				endcase
			end
		end
	end

	// dimensions in use, clamped
	always_comb begin
		if (width_q < CNT_W'(DIM_MIN))
			cfg.width = CNT_W'(DIM_MIN);
		else if (width_q > CNT_W'(W_CAP))
			cfg.width = CNT_W'(W_CAP);
		else
			cfg.width = width_q;
		if (height_q < CNT_W'(DIM_MIN))
			cfg.height = CNT_W'(DIM_MIN);
		else if (height_q > CNT_W'(DIM_MAX))
			cfg.height = CNT_W'(DIM_MAX);
		else
			cfg.height = height_q;
		cfg.center_w = center_q;
		cfg.side_w   = side_q;
		cfg.blur_en  = blur_en_q;
		cfg.restart  = restart_q;
	end

	hcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.valid      (f_valid),
		.front_item (f_item),
		.take       (f_take)
	);

	hcr_core #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (f_valid),
		.in_item   (f_item),
		.in_take   (f_take),
		.res_space (res_space),
		.res_wr    (res_wr),
		.res_data  (res_data)
	);

	hcr_res_fifo u_res (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_wr),
		.wr_data (res_data),
		.space   (res_space),
		.empty   (empty),
		.result  (result),
		.pop     (pop)
	);

endmodule
